### rtl/rtp_pkg.sv
package rtp_pkg;

    // Pixel and result field widths
    localparam int PIX_W      = 8;
    localparam int COL_OUT_W  = 7;
    localparam int PAGE_OUT_W = 3;

    // Page geometry: eight rows per page, one bit per row in a column byte
    localparam int ROW_W = 3;
    localparam logic [ROW_W-1:0] FIRST_ROW = 3'd0;
    localparam logic [ROW_W-1:0] LAST_ROW  = 3'd7;

    // A pixel is lit when its red level is above this threshold
    localparam logic [PIX_W-1:0] LIT_THRESHOLD = 8'h7F;

endpackage

### rtl/rtp_ram.sv
module rtp_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write one entry, read one entry into the output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rtp_pos_ctr.sv
module rtp_pos_ctr #(
    parameter int WIDTH = 128,
    parameter int PAGES = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_step,
    output logic [$clog2(WIDTH)-1:0]                o_col,
    output logic [rtp_pkg::ROW_W-1:0]               o_row,
    output logic [((PAGES > 1) ? $clog2(PAGES) : 1)-1:0] o_page
);

    import rtp_pkg::*;

    localparam int COL_W  = $clog2(WIDTH);
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;

    logic [COL_W-1:0]  r_col,  n_col;
    logic [ROW_W-1:0]  r_row,  n_row;
    logic [PAGE_W-1:0] r_page, n_page;

    // Advance column, then row within page, then page; wrap at frame end
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_page = r_page;
        if (i_step) begin
            if (r_col == COL_W'(WIDTH - 1)) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
                if (r_row == LAST_ROW) begin
                    if (r_page == PAGE_W'(PAGES - 1)) begin
                        n_page = '0;
                    end else begin
                        n_page = r_page + PAGE_W'(1);
                    end
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_page <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_page <= n_page;
        end
    end

    assign o_col  = r_col;
    assign o_row  = r_row;
    assign o_page = r_page;

endmodule

### rtl/raster_to_page_packer.sv
// Raster to page packer.
// Input channel (i_valid / o_ready) takes the red byte of one pixel per
// request, in raster order, WIDTH pixels per row. A pixel is lit when red
// is above 127. Each lit bit is merged into a per-column byte held in a
// WIDTH-entry line store RAM, at the bit of its row within the page.
// Output channel (o_valid / i_ready) gives one request per column on the
// eighth row of each page: the packed byte, its column, its page, and a
// frame-last flag on the last column of the last page.
// Throughput: one pixel per cycle unless the output stalls. Each pixel
// takes a RAM read in its accept cycle and is registered into the merge
// stage, which merges it and writes the byte back. o_valid for a packed
// byte comes from the output register, loaded as its last pixel leaves s1.
// Neighboring pixels always hit different columns, so the read and the
// write-back never touch the same entry at once.
// Reset clears the position counters and the pipeline; the line store is
// not cleared, since row 0 of every page overwrites each column first.
// When the receiver stalls, the output register holds its request and
// pixels that produce no output keep flowing until a second packed byte
// is waiting, at which point o_ready drops.
module raster_to_page_packer #(
    parameter int WIDTH = 128,
    parameter int PAGES = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [rtp_pkg::PIX_W-1:0]        i_red_level,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [rtp_pkg::PIX_W-1:0]        o_packed_byte,
    output logic [rtp_pkg::COL_OUT_W-1:0]    o_column_index,
    output logic [rtp_pkg::PAGE_OUT_W-1:0]   o_page_index,
    output logic                             o_frame_last
);

    import rtp_pkg::*;

    localparam int COL_W  = $clog2(WIDTH);
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;

    logic              in_acc;
    logic [COL_W-1:0]  pos_col;
    logic [ROW_W-1:0]  pos_row;
    logic [PAGE_W-1:0] pos_page;

    logic              r_s1_valid;
    logic              r_s1_lit;
    logic [COL_W-1:0]  r_s1_col;
    logic [ROW_W-1:0]  r_s1_row;
    logic [PAGE_W-1:0] r_s1_page;

    logic [PIX_W-1:0]  ram_rdata;
    logic [PIX_W-1:0]  n_byte;
    logic              s1_emit;
    logic              s1_adv;
    logic              s1_last;
    logic [31:0]       s1_col_ext;
    logic [31:0]       s1_page_ext;

    logic                  r_o_valid;
    logic [PIX_W-1:0]      r_o_byte;
    logic [COL_OUT_W-1:0]  r_o_col;
    logic [PAGE_OUT_W-1:0] r_o_page;
    logic                  r_o_last;

    assign in_acc = i_valid && o_ready;

    // Track the raster position of the next pixel
    rtp_pos_ctr #(
        .WIDTH (WIDTH),
        .PAGES (PAGES)
    ) u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_acc),
        .o_col   (pos_col),
        .o_row   (pos_row),
        .o_page  (pos_page)
    );

    // Line store: read the column byte on accept, write the merge back
    rtp_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (n_byte),
        .i_re    (in_acc),
        .i_raddr (pos_col),
        .o_rdata (ram_rdata)
    );

    // Merge stage: overwrite on the first row, else OR in the new bit
    assign s1_emit = (r_s1_row == LAST_ROW);
    assign s1_adv  = r_s1_valid && (!s1_emit || !r_o_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_adv;

    always_comb begin
        if (r_s1_row == FIRST_ROW) begin
            n_byte = PIX_W'(r_s1_lit);
        end else begin
            n_byte = ram_rdata | (PIX_W'(r_s1_lit) << r_s1_row);
        end
    end

    assign s1_last     = (r_s1_col == COL_W'(WIDTH - 1)) &&
                         (r_s1_page == PAGE_W'(PAGES - 1));
    assign s1_col_ext  = 32'(r_s1_col);
    assign s1_page_ext = 32'(r_s1_page);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Capture the pixel and its position on accept
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_lit  <= (i_red_level > LIT_THRESHOLD);
            r_s1_col  <= pos_col;
            r_s1_row  <= pos_row;
            r_s1_page <= pos_page;
        end
    end

    // Output register: load a finished column byte, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv && s1_emit) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_emit) begin
            r_o_byte <= n_byte;
            r_o_col  <= s1_col_ext[COL_OUT_W-1:0];
            r_o_page <= s1_page_ext[PAGE_OUT_W-1:0];
            r_o_last <= s1_last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_packed_byte  = r_o_byte;
    assign o_column_index = r_o_col;
    assign o_page_index   = r_o_page;
    assign o_frame_last   = r_o_last;

endmodule

### rtl/rtp_checker.sv
module rtp_checker #(
    parameter int WIDTH = 128,
    parameter int PAGES = 8
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_ready,
    input logic [rtp_pkg::PIX_W-1:0]        i_red_level,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic [rtp_pkg::PIX_W-1:0]        o_packed_byte,
    input logic [rtp_pkg::COL_OUT_W-1:0]    o_column_index,
    input logic [rtp_pkg::PAGE_OUT_W-1:0]   o_page_index,
    input logic                             o_frame_last
);

    import rtp_pkg::*;

    logic [31:0] last_col_ext;
    logic [31:0] last_page_ext;

    assign last_col_ext  = 32'(WIDTH - 1);
    assign last_page_ext = 32'(PAGES - 1);

    // Hold a waiting input request and its pixel
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_red_level))
        else $error("input request dropped or changed while waiting");

    // Hold a stalled output request
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output request dropped while stalled");

    // Keep the stalled payload unchanged
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_packed_byte) && $stable(o_column_index)
            && $stable(o_page_index) && $stable(o_frame_last))
        else $error("output payload changed while stalled");

    // Come out of reset with no output pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Flag frame end only on the last column of the last page
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_last |->
            (o_column_index == last_col_ext[COL_OUT_W-1:0]) &&
            (o_page_index == last_page_ext[PAGE_OUT_W-1:0]))
        else $error("frame end flagged at wrong position");

endmodule

bind raster_to_page_packer rtp_checker #(
    .WIDTH (WIDTH),
    .PAGES (PAGES)
) u_rtp_checker (.*);

### tb/sv/tb_raster_to_page_packer.sv
module tb_raster_to_page_packer;
    timeunit 1ns;
    timeprecision 1ps;

    import rtp_pkg::*;

    localparam int WIDTH        = 128;
    localparam int PAGES        = 8;
    localparam int N_PIXELS     = 1200;
    localparam int N_EDGE       = 25;
    localparam int HOLD_AT_A    = 980;
    localparam int HOLD_AT_B    = 1010;
    localparam int STEADY_FROM  = 860;
    localparam int STEADY_TO    = 940;
    localparam int IDLE_PCT     = 15;
    localparam int DRAIN_CYCLES = 8;

    // Threshold neighbors, single bits, the rail values and mixed patterns
    localparam logic [PIX_W-1:0] EDGE_LEVELS [N_EDGE] = '{
        8'h00, 8'hFF, 8'h7F, 8'h80, 8'h01, 8'hFE, 8'h7E, 8'h81, 8'h40,
        8'hC0, 8'h20, 8'hA0, 8'h10, 8'h90, 8'h08, 8'h88, 8'h04, 8'h84,
        8'h02, 8'h82, 8'h55, 8'hAA, 8'h3F, 8'hBF, 8'hFF
    };

    typedef struct packed {
        logic [PIX_W-1:0]      packed_byte;
        logic [COL_OUT_W-1:0]  column_index;
        logic [PAGE_OUT_W-1:0] page_index;
        logic                  frame_last;
    } t_page_byte;

    class t_page_byte_checker #(int W = 128, int P = 8);
        logic [PIX_W-1:0] column_bits [W];
        int unsigned      column_now;
        logic [ROW_W-1:0] row_now;
        int unsigned      page_now;
        t_page_byte       expected_bytes [$];
        int               errors;

        function new();
            foreach (column_bits[i]) column_bits[i] = '0;
            column_now = 0;
            row_now    = FIRST_ROW;
            page_now   = 0;
            errors     = 0;
        endfunction

        function int outstanding();
            return expected_bytes.size();
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("MISMATCH at %0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
            errors++;
        endtask

        // Merge one accepted pixel and queue the byte that row 7 completes
        function void note_pixel(logic [PIX_W-1:0] level);
            logic       lit;
            t_page_byte want;
            lit = (level > LIT_THRESHOLD);
            if (row_now == FIRST_ROW) begin
                column_bits[column_now] = PIX_W'(lit);
            end else begin
                column_bits[column_now] = column_bits[column_now] | (PIX_W'(lit) << row_now);
            end
            if (row_now == LAST_ROW) begin
                want.packed_byte  = column_bits[column_now];
                want.column_index = COL_OUT_W'(column_now);
                want.page_index   = PAGE_OUT_W'(page_now);
                want.frame_last   = (column_now == W - 1) && (page_now == P - 1);
                expected_bytes.push_back(want);
            end
            // Advance column, then row, then page; wrap at frame end
            column_now++;
            if (column_now == W) begin
                column_now = 0;
                if (row_now == LAST_ROW) begin
                    row_now  = FIRST_ROW;
                    page_now = (page_now == P - 1) ? 0 : page_now + 1;
                end else begin
                    row_now = row_now + 1'b1;
                end
            end
        endfunction

        task check_byte(t_page_byte got);
            t_page_byte want;
            if (expected_bytes.size() == 0) begin
                report_mismatch("byte with none pending, packed_byte", got.packed_byte, 0);
            end else begin
                want = expected_bytes.pop_front();
                if (got.packed_byte !== want.packed_byte)
                    report_mismatch("packed_byte", got.packed_byte, want.packed_byte);
                if (got.column_index !== want.column_index)
                    report_mismatch("column_index", got.column_index, want.column_index);
                if (got.page_index !== want.page_index)
                    report_mismatch("page_index", got.page_index, want.page_index);
                if (got.frame_last !== want.frame_last)
                    report_mismatch("frame_last", got.frame_last, want.frame_last);
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [PIX_W-1:0]      i_red_level;
    logic                  o_valid;
    logic                  i_ready;
    logic [PIX_W-1:0]      o_packed_byte;
    logic [COL_OUT_W-1:0]  o_column_index;
    logic [PAGE_OUT_W-1:0] o_page_index;
    logic                  o_frame_last;

    bit steady = 1'b0;
    t_page_byte_checker #(WIDTH, PAGES) sb;

    raster_to_page_packer #(
        .WIDTH (WIDTH),
        .PAGES (PAGES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_red_level    (i_red_level),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_packed_byte  (o_packed_byte),
        .o_column_index (o_column_index),
        .o_page_index   (o_page_index),
        .o_frame_last   (o_frame_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the receiver at random, except during the steady stretch
    always @(negedge i_clk) begin
        i_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Capture accepted requests on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_pixel(i_red_level);
            if (o_valid && i_ready) begin
                sb.check_byte('{o_packed_byte, o_column_index, o_page_index, o_frame_last});
            end
        end
    end

    // Bias toward the rails and the threshold, otherwise uniform
    function automatic logic [PIX_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'h7F;
            1:       return 8'h80;
            2:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Present one pixel and hold it until the block takes it
    task automatic send_pixel(input logic [PIX_W-1:0] level);
        @(negedge i_clk);
        while (!steady && ($urandom_range(0, 99) < IDLE_PCT)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_red_level <= level;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid and wait until every pending byte is out
    task automatic hold_until_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
    endtask

    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_red_level = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Edge levels first, then random pixels through the first page and into the second
        for (int k = 0; k < N_PIXELS; k++) begin
            if (k == HOLD_AT_A || k == HOLD_AT_B) hold_until_drained();
            steady = (k >= STEADY_FROM) && (k < STEADY_TO);
            send_pixel((k < N_EDGE) ? EDGE_LEVELS[k] : pick_level());
        end
        steady = 1'b0;
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

### raster_to_page_packer.f
rtl/rtp_pkg.sv
rtl/rtp_ram.sv
rtl/rtp_pos_ctr.sv
rtl/raster_to_page_packer.sv
rtl/rtp_checker.sv
tb/sv/tb_raster_to_page_packer.sv
